/* rtl/core/fca_pkg.sv */
// Shared types and constants for the FAT16 cluster allocator.
// No dependencies; imported by the controller, datapath and top level.
package fca_pkg;

  localparam int unsigned TableEntries = 65536;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned LimW = IdxW + 1;

  localparam logic [15:0] EntryFree   = 16'h0000;
  localparam logic [15:0] EntryLast   = 16'hFFFF;
  localparam logic [15:0] EocLow      = 16'hFFF8;
  localparam logic [15:0] ReservedLow = 16'hfff0;
  localparam logic [15:0] FirstData   = 16'd2;

  localparam logic [2:0] ModeLoad   = 3'd0;
  localparam logic [2:0] ModeRead   = 3'd1;
  localparam logic [2:0] ModeFree   = 3'd2;
  localparam logic [2:0] ModeLast   = 3'd3;
  localparam logic [2:0] ModeAlloc  = 3'd4;
  localparam logic [2:0] ModeFreeCh = 3'd5;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StFull   = 3'd1;
  localparam logic [2:0] StFree   = 3'd2;
  localparam logic [2:0] StLast   = 3'd3;
  localparam logic [2:0] StTail   = 3'd4;
  localparam logic [2:0] StBroken = 3'd5;

  // Address source for the table port.
  typedef enum logic [1:0] {
    AddrReq,
    AddrCur,
    AddrLink
  } addr_sel_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic      capture;    // latch the request
    logic      rd_en;      // issue a table read
    addr_sel_e addr_sel;
    logic      wr_en;      // write wr_data, or the value picked by wr_cur/wr_ev, to addr_sel
    logic [15:0] wr_data;
    logic      wr_cur;     // write data is the current cluster
    logic      wr_ev;      // write data is the captured entry value
    logic      cur_init;   // load the search/walk pointer
    logic      cur_step;   // advance search pointer with wrap
    logic      cur_link;   // move walk pointer to last read link
    logic      cnt_clr;
    logic      ptr_save;   // save current into search_start
    logic      done;
    logic [2:0] st;
    logic      res_cur;    // result is current cluster
    logic      res_rd;     // result is read data
  } fca_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [2:0] mode;
    logic       link;
    logic       rd_free;
    logic       rd_eoc;
    logic       rd_bad;    // link invalid for a chain walk
    logic       in_range;  // addressed cluster within table
    logic       cnt_done;  // search covered every data entry
  } fca_stat_t;

endpackage

/* rtl/core/fca_datapath.sv */
// Datapath of the FAT16 cluster allocator: table memory, pointers, result.
// Depends on fca_pkg.
module fca_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        mode_i,
  input  logic [15:0]       cluster_i,
  input  logic [15:0]       entry_value_i,
  input  logic              link_tail_i,
  input  logic [16:0]       limit_i,
  input  fca_pkg::fca_cmd_t cmd_i,
  output fca_pkg::fca_stat_t stat_o,
  output logic              strobe_o,
  output logic [15:0]       result_cluster_o,
  output logic [2:0]        status_o
);
  import fca_pkg::*;

  logic [15:0] mem_q [TableEntries];
  logic [15:0] rd_q;
  logic [2:0]  mode_q;
  logic [15:0] cl_q, ev_q, cur_q, srch_q;
  logic        link_q;
  logic [16:0] lim_q, cnt_q;
  logic [IdxW-1:0] addr;
  logic [15:0] wdata;
  logic [16:0] lim_eff;

  always_comb begin
    lim_eff = limit_i;
    if (limit_i > 17'(TableEntries)) lim_eff = 17'(TableEntries);
    if (limit_i < 17'd3) lim_eff = 17'd3;
  end

  always_comb begin
    case (cmd_i.addr_sel)
      AddrReq:  addr = IdxW'(cl_q);
      AddrCur:  addr = IdxW'(cur_q);
      AddrLink: addr = IdxW'(rd_q);
      default:  addr = IdxW'(cl_q);
    endcase
    wdata = cmd_i.wr_cur ? cur_q : (cmd_i.wr_ev ? ev_q : cmd_i.wr_data);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[addr] <= wdata;
    if (cmd_i.rd_en) rd_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      cl_q   <= cluster_i;
      ev_q   <= entry_value_i;
      link_q <= link_tail_i;
      lim_q  <= lim_eff;
    end
    if (cmd_i.cur_init) begin
      if (mode_q == ModeFreeCh) cur_q <= cl_q;
      else if (srch_q < FirstData || {1'b0, srch_q} >= lim_q) cur_q <= FirstData;
      else cur_q <= srch_q;
    end else if (cmd_i.cur_step) begin
      if ({1'b0, cur_q} + 17'd1 >= lim_q) cur_q <= FirstData;
      else cur_q <= cur_q + 16'd1;
    end else if (cmd_i.cur_link) begin
      cur_q <= rd_q;
    end
    if (cmd_i.cnt_clr) cnt_q <= '0;
    else if (cmd_i.cur_step) cnt_q <= cnt_q + 17'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_q           <= FirstData;
      strobe_o         <= 1'b0;
      result_cluster_o <= '0;
      status_o         <= StOk;
    end else begin
      if (cmd_i.ptr_save) srch_q <= cur_q;
      strobe_o <= cmd_i.done;
      if (cmd_i.done) begin
        status_o <= cmd_i.st;
        if (cmd_i.st != StOk) result_cluster_o <= '0;
        else if (cmd_i.res_cur) result_cluster_o <= cur_q;
        else if (cmd_i.res_rd) result_cluster_o <= rd_q;
        else result_cluster_o <= '0;
      end
    end
  end

  always_comb begin
    stat_o.mode     = mode_q;
    stat_o.link     = link_q;
    stat_o.rd_free  = (rd_q == EntryFree);
    stat_o.rd_eoc   = (rd_q >= EocLow);
    stat_o.rd_bad   = (rd_q < FirstData) || ({1'b0, rd_q} >= lim_q) || (rd_q >= ReservedLow);
    stat_o.in_range = ({1'b0, cl_q} < 17'(TableEntries));
    stat_o.cnt_done = (cnt_q >= lim_q - 17'd2);
  end

endmodule

/* rtl/core/fca_ctrl.sv */
// Controller state machine of the FAT16 cluster allocator.
// Depends on fca_pkg.
module fca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  fca_pkg::fca_stat_t stat_i,
  output fca_pkg::fca_cmd_t  cmd_o,
  output logic               busy_o
);
  import fca_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SRdReq, SWaitReq, SDecide, SSrchRd, SSrchWait, SSrchChk,
    SWalkRd, SWalkWait, SWalkChk
  } state_e;

  state_e state_q, state_d;
  logic first_q, first_d;

  always_comb begin
    cmd_o    = '0;
    cmd_o.addr_sel = AddrReq;
    state_d  = state_q;
    first_d  = first_q;
    case (state_q)
      SIdle: if (start_i) begin
        cmd_o.capture = 1'b1;
        state_d = SRdReq;
      end
      SRdReq: begin
        if (stat_i.mode == ModeLoad) begin
          cmd_o.wr_en = stat_i.in_range;
          cmd_o.wr_ev = 1'b1;
          cmd_o.done = 1'b1;
          cmd_o.st = StOk;
          state_d = SIdle;
        end else if (stat_i.mode == ModeAlloc && !stat_i.link) begin
          cmd_o.cur_init = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d = SSrchRd;
        end else if (stat_i.mode == ModeFreeCh) begin
          cmd_o.cur_init = 1'b1;
          first_d = 1'b1;
          state_d = SWalkRd;
        end else if (stat_i.mode > ModeFreeCh) begin
          cmd_o.done = 1'b1;
          cmd_o.st = StOk;
          state_d = SIdle;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = SWaitReq;
        end
      end
      SWaitReq: state_d = SDecide;
      SDecide: begin
        case (stat_i.mode)
          ModeRead: begin
            cmd_o.done = 1'b1; cmd_o.res_rd = 1'b1; cmd_o.st = StOk;
            state_d = SIdle;
          end
          ModeFree: begin
            cmd_o.done = 1'b1;
            cmd_o.st = stat_i.rd_free ? StFree : StOk;
            cmd_o.wr_en = !stat_i.rd_free;
            cmd_o.wr_data = EntryFree;
            state_d = SIdle;
          end
          ModeLast: begin
            cmd_o.done = 1'b1;
            cmd_o.st = stat_i.rd_eoc ? StLast : StOk;
            cmd_o.wr_en = !stat_i.rd_eoc;
            cmd_o.wr_data = EntryLast;
            state_d = SIdle;
          end
          default: begin
            if (!stat_i.rd_eoc) begin
              cmd_o.done = 1'b1; cmd_o.st = StTail;
              state_d = SIdle;
            end else begin
              cmd_o.cur_init = 1'b1;
              cmd_o.cnt_clr = 1'b1;
              state_d = SSrchRd;
            end
          end
        endcase
      end
      SSrchRd: begin
        if (stat_i.cnt_done) begin
          cmd_o.done = 1'b1; cmd_o.st = StFull;
          state_d = SIdle;
        end else begin
          cmd_o.addr_sel = AddrCur;
          cmd_o.rd_en = 1'b1;
          state_d = SSrchWait;
        end
      end
      SSrchWait: state_d = SSrchChk;
      SSrchChk: begin
        if (stat_i.rd_free) begin
          cmd_o.addr_sel = AddrCur;
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_data = EntryLast;
          cmd_o.ptr_save = 1'b1;
          if (stat_i.link) state_d = SWalkChk;
          else begin
            cmd_o.done = 1'b1; cmd_o.res_cur = 1'b1; cmd_o.st = StOk;
            state_d = SIdle;
          end
        end else begin
          cmd_o.cur_step = 1'b1;
          state_d = SSrchRd;
        end
      end
      SWalkRd: begin
        cmd_o.addr_sel = AddrCur;
        cmd_o.rd_en = 1'b1;
        state_d = SWalkWait;
      end
      SWalkWait: state_d = (stat_i.mode == ModeAlloc) ? SIdle : SWalkChk;
      SWalkChk: begin
        if (stat_i.mode == ModeAlloc) begin
          // link the new cluster after the tail
          cmd_o.addr_sel = AddrReq;
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_cur = 1'b1;
          cmd_o.done = 1'b1; cmd_o.res_cur = 1'b1; cmd_o.st = StOk;
          state_d = SIdle;
        end else if (stat_i.rd_free) begin
          cmd_o.done = 1'b1;
          cmd_o.st = first_q ? StFree : StBroken;
          state_d = SIdle;
        end else begin
          cmd_o.addr_sel = AddrCur;
          cmd_o.wr_en = 1'b1;
          cmd_o.wr_data = EntryFree;
          first_d = 1'b0;
          if (stat_i.rd_eoc) begin
            cmd_o.done = 1'b1; cmd_o.st = StOk; state_d = SIdle;
          end else if (stat_i.rd_bad) begin
            cmd_o.done = 1'b1; cmd_o.st = StBroken; state_d = SIdle;
          end else begin
            cmd_o.cur_link = 1'b1;
            state_d = SWalkRd;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  assign busy_o = (state_q != SIdle);

endmodule

/* rtl/core/fat16_cluster_allocator.sv */
// Top level of the FAT16 cluster allocator: controller plus datapath.
// Depends on fca_pkg, fca_ctrl and fca_datapath.
//
// Usage: raise start_i with a request while busy_o is low; the request is
// taken at that edge. Exactly one result comes back, shown for one cycle with
// done_o high; the receiver cannot stall it, so sample it then. The result
// cycle is also the first cycle in which the next request can be taken.
// Load and the unused modes finish without a table read; read, free one,
// mark last and a failed tail check do one table read. Allocate probes
// table entries from the next-fit pointer (one read of the single table
// port each), with a tail read first and a link write last when linking
// after a tail; free chain reads and frees each entry of the chain. The user
// must write cluster_limit with cfg_we_i only while idle; the block itself
// does not enforce this; the table contents are undefined until loaded and
// must be written before they are read.
module fat16_cluster_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic [15:0] cluster_i,
  input  logic [15:0] entry_value_i,
  input  logic        link_tail_i,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  output logic        done_o,
  output logic [15:0] result_cluster_o,
  output logic [2:0]  status_o
);
  import fca_pkg::*;

  fca_cmd_t  cmd;
  fca_stat_t stat;
  logic [16:0] limit_q;

  // Hold the cluster limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 17'(TableEntries);
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  fca_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i,
    .stat_i(stat), .cmd_o(cmd), .busy_o
  );

  fca_datapath u_dp (
    .clk_i, .rst_ni, .mode_i, .cluster_i, .entry_value_i, .link_tail_i,
    .limit_i(limit_q), .cmd_i(cmd), .stat_o(stat), .strobe_o(done_o),
    .result_cluster_o, .status_o
  );

`ifndef SYNTHESIS
  // A result goes out only while the block is idle.
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("done while busy");
  // An error status always carries a zero cluster.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StOk) |-> result_cluster_o == '0)
    else $error("error with nonzero result");
  // The strobe follows a busy cycle.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(busy_o))
    else $error("done without request");
`endif

endmodule
